// ===== hw/rtl/psw_pkg.sv =====
// Shared types and constants for the pixel sinc wave block.
// No dependencies; every other file of the block refers to this package by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package psw_pkg;

    localparam logic [63:0] PI62 = 64'hC90FDAA22168C235;
    localparam logic [63:0] PI30 = ((PI62 >> 31) + 64'd1) >> 1;
    localparam logic [63:0] HP30 = ((PI62 >> 32) + 64'd1) >> 1;

    localparam int DATA_W = 32;
    localparam int RED_W  = 61;
    localparam int ANG_W  = 34;
    localparam int MAG_W  = 31;
    localparam int SQ_W   = 32;
    localparam int SUM_W  = 34;
    localparam int CFG_W  = 3;

    typedef enum logic [CFG_W-1:0] {
        CFG_EQUAL_MODE = 3'd0,
        CFG_PHASE_X    = 3'd1,
        CFG_PHASE_Y    = 3'd2,
        CFG_PHASE_Z    = 3'd3,
        CFG_PHASE_W    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              clip;
    } t_chan_res;

    function automatic int latency(int sine_steps);
        return 3 * sine_steps + 67;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/psw_reduce_cell.sv =====
// One cell of the angle reduction chain: a single restoring step against a shifted 2*pi.
// Depends on psw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psw_reduce_cell #(
    parameter int FRAC_BITS = 16,
    parameter int SHIFT     = 0
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [31:0]         i_v,
    input  logic                       i_negs,
    input  logic [psw_pkg::RED_W-1:0]  i_rem,
    output logic signed [31:0]         o_v,
    output logic                       o_negs,
    output logic [psw_pkg::RED_W-1:0]  o_rem
);

    localparam int RW = psw_pkg::RED_W;
    localparam logic [63:0] TP     = ((psw_pkg::PI62 >> (32 - FRAC_BITS)) + 64'd1) >> 1;
    localparam logic [63:0] STEP64 = TP << SHIFT;
    localparam logic [RW-1:0] STEP = STEP64[RW-1:0];

    logic signed [31:0] r_v;
    logic               r_negs;
    logic [RW-1:0]      r_rem;
    logic [RW-1:0]      n_rem;

    always_comb begin
        if (i_rem >= STEP) begin
            n_rem = i_rem - STEP;
        end else begin
            n_rem = i_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= i_v;
            r_negs <= i_negs;
            r_rem  <= n_rem;
        end
    end

    assign o_v    = r_v;
    assign o_negs = r_negs;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== hw/rtl/psw_sine_cell.sv =====
// One cell of the sine series chain: next Taylor term and running sum, in three stages.
// Depends on psw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psw_sine_cell #(
    parameter int K = 1
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [31:0]               i_v,
    input  logic                             i_neg,
    input  logic [psw_pkg::SQ_W-1:0]         i_r2,
    input  logic [psw_pkg::MAG_W-1:0]        i_term,
    input  logic signed [psw_pkg::SUM_W-1:0] i_sum,
    output logic signed [31:0]               o_v,
    output logic                             o_neg,
    output logic [psw_pkg::SQ_W-1:0]         o_r2,
    output logic [psw_pkg::MAG_W-1:0]        o_term,
    output logic signed [psw_pkg::SUM_W-1:0] o_sum
);

    localparam int SQW = psw_pkg::SQ_W;
    localparam int MW  = psw_pkg::MAG_W;
    localparam int SW  = psw_pkg::SUM_W;
    localparam int D   = 2 * K * (2 * K + 1);
    localparam logic [63:0] M64 = (64'd1 << 34) / D;
    localparam logic [31:0] M   = M64[31:0];
    localparam bit ODD = (K % 2) == 1;

    logic signed [31:0]   r_a_v, r_b_v, r_c_v;
    logic                 r_a_neg, r_b_neg, r_c_neg;
    logic [SQW-1:0]       r_a_r2, r_b_r2, r_c_r2;
    logic signed [SW-1:0] r_a_sum, r_b_sum, r_c_sum;
    logic [32:0]          r_a_p, r_b_p;
    logic [MW-1:0]        r_b_qe, r_c_term;

    logic [62:0]          prod_a;
    logic [64:0]          prod_b;
    logic [43:0]          prod_c;
    logic [43:0]          rem_c;
    logic [MW-1:0]        n_term;
    logic signed [SW-1:0] n_sum;

    always_comb begin
        prod_a = 63'(i_term) * 63'(i_r2);
        prod_b = 65'(r_a_p) * 65'(M);
        prod_c = 44'(r_b_qe) * 44'(D);
        rem_c  = 44'(r_b_p) - prod_c;
        if (rem_c >= 44'(D)) begin
            n_term = r_b_qe + 31'd1;
        end else begin
            n_term = r_b_qe;
        end
        if (ODD) begin
            n_sum = r_b_sum - $signed({3'b000, n_term});
        end else begin
            n_sum = r_b_sum + $signed({3'b000, n_term});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_v    <= i_v;
            r_a_neg  <= i_neg;
            r_a_r2   <= i_r2;
            r_a_sum  <= i_sum;
            r_a_p    <= prod_a[62:30];
            r_b_v    <= r_a_v;
            r_b_neg  <= r_a_neg;
            r_b_r2   <= r_a_r2;
            r_b_sum  <= r_a_sum;
            r_b_p    <= r_a_p;
            r_b_qe   <= prod_b[64:34];
            r_c_v    <= r_b_v;
            r_c_neg  <= r_b_neg;
            r_c_r2   <= r_b_r2;
            r_c_sum  <= n_sum;
            r_c_term <= n_term;
        end
    end

    assign o_v    = r_c_v;
    assign o_neg  = r_c_neg;
    assign o_r2   = r_c_r2;
    assign o_term = r_c_term;
    assign o_sum  = r_c_sum;

endmodule

`default_nettype wire

// ===== hw/rtl/psw_div_cell.sv =====
// One cell of the quotient chain: a single restoring division step producing one bit.
// Depends on psw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psw_div_cell #(
    parameter int FRAC_BITS = 16,
    parameter int POS       = 0,
    parameter int QW        = 48
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [psw_pkg::SUM_W-1:0] i_s,
    input  logic                             i_sneg,
    input  logic                             i_vneg,
    input  logic                             i_vzero,
    input  logic [31:0]                      i_vmag,
    input  logic [31:0]                      i_smag,
    input  logic [31:0]                      i_rem,
    input  logic [QW-1:0]                    i_quo,
    output logic signed [psw_pkg::SUM_W-1:0] o_s,
    output logic                             o_sneg,
    output logic                             o_vneg,
    output logic                             o_vzero,
    output logic [31:0]                      o_vmag,
    output logic [31:0]                      o_smag,
    output logic [31:0]                      o_rem,
    output logic [QW-1:0]                    o_quo
);

    localparam int SW = psw_pkg::SUM_W;

    logic                 nb;
    logic [32:0]          trial;
    logic [31:0]          n_rem;
    logic                 qbit;
    logic signed [SW-1:0] r_s;
    logic                 r_sneg, r_vneg, r_vzero;
    logic [31:0]          r_vmag, r_smag, r_rem;
    logic [QW-1:0]        r_quo;

    if (POS >= FRAC_BITS) begin : g_bit
        assign nb = i_smag[POS-FRAC_BITS];
    end else begin : g_zero
        assign nb = 1'b0;
    end

    always_comb begin
        trial = {i_rem, nb};
        if (trial >= {1'b0, i_vmag}) begin
            n_rem = 32'(trial - {1'b0, i_vmag});
            qbit  = 1'b1;
        end else begin
            n_rem = trial[31:0];
            qbit  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s     <= i_s;
            r_sneg  <= i_sneg;
            r_vneg  <= i_vneg;
            r_vzero <= i_vzero;
            r_vmag  <= i_vmag;
            r_smag  <= i_smag;
            r_rem   <= n_rem;
            r_quo   <= {i_quo[QW-2:0], qbit};
        end
    end

    assign o_s     = r_s;
    assign o_sneg  = r_sneg;
    assign o_vneg  = r_vneg;
    assign o_vzero = r_vzero;
    assign o_vmag  = r_vmag;
    assign o_smag  = r_smag;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

endmodule

`default_nettype wire

// ===== hw/rtl/psw_channel.sv =====
// One channel lane: reduction cells, quadrant fold, sine cells, quotient cells and output.
// Depends on psw_pkg, psw_reduce_cell, psw_sine_cell and psw_div_cell.
`timescale 1ns / 1ps
`default_nettype none

module psw_channel #(
    parameter int FRAC_BITS  = 16,
    parameter int SINE_STEPS = 20
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_v,
    input  logic signed [31:0] i_t,
    output psw_pkg::t_chan_res o_res
);

    localparam int RW  = psw_pkg::RED_W;
    localparam int AW  = psw_pkg::ANG_W;
    localparam int MW  = psw_pkg::MAG_W;
    localparam int SQW = psw_pkg::SQ_W;
    localparam int SW  = psw_pkg::SUM_W;
    localparam int QB  = 30 - FRAC_BITS;
    localparam int QD  = 32 + FRAC_BITS;
    localparam int NS  = SINE_STEPS - 1;
    localparam int SH  = 31 - FRAC_BITS;
    localparam int WW  = QD + 2;
    localparam logic [63:0] TP64 = ((psw_pkg::PI62 >> (32 - FRAC_BITS)) + 64'd1) >> 1;
    localparam logic [RW-1:0] TP = TP64[RW-1:0];
    localparam logic [AW-1:0] PI30 = psw_pkg::PI30[AW-1:0];
    localparam logic [AW-1:0] HP30 = psw_pkg::HP30[AW-1:0];
    localparam logic [63:0] ADD64 = (64'd1 << 30) + (64'd1 << (30 - FRAC_BITS));
    localparam logic [WW-1:0] ADDC = ADD64[WW-1:0];

    // Input stage.
    logic signed [32:0] s_sum;
    logic [32:0]        s_abs;
    logic signed [31:0] red_v    [QB+1];
    logic               red_negs [QB+1];
    logic [RW-1:0]      red_rem  [QB+1];

    always_comb begin
        s_sum = 33'(i_v) + 33'(i_t);
        s_abs = s_sum[32] ? 33'(-s_sum) : 33'(s_sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            red_v[0]    <= i_v;
            red_negs[0] <= s_sum[32];
            red_rem[0]  <= {s_abs, 28'd0};
        end
    end

    for (genvar i = 0; i < QB; i++) begin : g_red
        psw_reduce_cell #(
            .FRAC_BITS(FRAC_BITS),
            .SHIFT    (QB - 1 - i)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_v   (red_v[i]),
            .i_negs(red_negs[i]),
            .i_rem (red_rem[i]),
            .o_v   (red_v[i+1]),
            .o_negs(red_negs[i+1]),
            .o_rem (red_rem[i+1])
        );
    end

    // Quadrant fold over three stages.
    logic [RW-1:0]        fix_r;
    logic [RW-1:0]        fix_sh;
    logic [AW-1:0]        r_q1_ang, r_q2_ang, n_q2_ang;
    logic                 r_q2_neg, n_q2_neg, r_q3_neg;
    logic signed [31:0]   r_q1_v, r_q2_v, r_q3_v;
    logic signed [AW:0]   fold_d;
    logic [MW-1:0]        n_mag, r_q3_mag;
    logic [61:0]          sq_prod;
    logic signed [31:0]   sin_v    [NS+1];
    logic                 sin_neg  [NS+1];
    logic [SQW-1:0]       sin_r2   [NS+1];
    logic [MW-1:0]        sin_term [NS+1];
    logic signed [SW-1:0] sin_sum  [NS+1];

    always_comb begin
        if (red_negs[QB] && (red_rem[QB] != '0)) begin
            fix_r = TP - red_rem[QB];
        end else begin
            fix_r = red_rem[QB];
        end
        fix_sh = fix_r >> (FRAC_BITS - 2);

        if (r_q1_ang >= PI30) begin
            n_q2_neg = 1'b1;
            n_q2_ang = r_q1_ang - PI30;
        end else begin
            n_q2_neg = 1'b0;
            n_q2_ang = r_q1_ang;
        end

        fold_d = $signed({1'b0, PI30}) - $signed({1'b0, r_q2_ang});
        if (r_q2_ang > HP30) begin
            n_mag = fold_d[AW] ? '0 : fold_d[MW-1:0];
        end else begin
            n_mag = r_q2_ang[MW-1:0];
        end

        sq_prod = 62'(r_q3_mag) * 62'(r_q3_mag);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1_ang    <= fix_sh[AW-1:0];
            r_q1_v      <= red_v[QB];
            r_q2_ang    <= n_q2_ang;
            r_q2_neg    <= n_q2_neg;
            r_q2_v      <= r_q1_v;
            r_q3_mag    <= n_mag;
            r_q3_neg    <= r_q2_neg;
            r_q3_v      <= r_q2_v;
            sin_v[0]    <= r_q3_v;
            sin_neg[0]  <= r_q3_neg;
            sin_r2[0]   <= sq_prod[61:30];
            sin_term[0] <= r_q3_mag;
            sin_sum[0]  <= $signed({3'b000, r_q3_mag});
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_sine
        psw_sine_cell #(
            .K(k + 1)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_v   (sin_v[k]),
            .i_neg (sin_neg[k]),
            .i_r2  (sin_r2[k]),
            .i_term(sin_term[k]),
            .i_sum (sin_sum[k]),
            .o_v   (sin_v[k+1]),
            .o_neg (sin_neg[k+1]),
            .o_r2  (sin_r2[k+1]),
            .o_term(sin_term[k+1]),
            .o_sum (sin_sum[k+1])
        );
    end

    // Signs and magnitudes ahead of the quotient chain.
    logic signed [SW-1:0] n_s;
    logic [SW-1:0]        n_smag;
    logic signed [31:0]   fin_v;
    logic [32:0]          n_vmag;
    logic signed [SW-1:0] div_s     [QD+1];
    logic                 div_sneg  [QD+1];
    logic                 div_vneg  [QD+1];
    logic                 div_vzero [QD+1];
    logic [31:0]          div_vmag  [QD+1];
    logic [31:0]          div_smag  [QD+1];
    logic [31:0]          div_rem   [QD+1];
    logic [QD-1:0]        div_quo   [QD+1];

    always_comb begin
        fin_v  = sin_v[NS];
        n_s    = sin_neg[NS] ? -sin_sum[NS] : sin_sum[NS];
        n_smag = sin_sum[NS][SW-1] ? SW'(-sin_sum[NS]) : SW'(sin_sum[NS]);
        n_vmag = fin_v[31] ? 33'(-33'(fin_v)) : 33'(fin_v);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            div_s[0]     <= n_s;
            div_sneg[0]  <= n_s[SW-1];
            div_vneg[0]  <= fin_v[31];
            div_vzero[0] <= (fin_v == '0);
            div_vmag[0]  <= n_vmag[31:0];
            div_smag[0]  <= n_smag[31:0];
            div_rem[0]   <= '0;
            div_quo[0]   <= '0;
        end
    end

    for (genvar i = 0; i < QD; i++) begin : g_div
        psw_div_cell #(
            .FRAC_BITS(FRAC_BITS),
            .POS      (QD - 1 - i),
            .QW       (QD)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_s    (div_s[i]),
            .i_sneg (div_sneg[i]),
            .i_vneg (div_vneg[i]),
            .i_vzero(div_vzero[i]),
            .i_vmag (div_vmag[i]),
            .i_smag (div_smag[i]),
            .i_rem  (div_rem[i]),
            .i_quo  (div_quo[i]),
            .o_s    (div_s[i+1]),
            .o_sneg (div_sneg[i+1]),
            .o_vneg (div_vneg[i+1]),
            .o_vzero(div_vzero[i+1]),
            .o_vmag (div_vmag[i+1]),
            .o_smag (div_smag[i+1]),
            .o_rem  (div_rem[i+1]),
            .o_quo  (div_quo[i+1])
        );
    end

    // Signed quotient, then offset, rounding shift and saturation.
    logic signed [QD:0]   q_pos;
    logic signed [QD:0]   n_q, r_q;
    logic signed [WW-1:0] w_sum;
    logic signed [WW-1:0] w_sh;
    psw_pkg::t_chan_res   n_res, r_res;

    always_comb begin
        q_pos = $signed({1'b0, div_quo[QD]});
        if (div_vzero[QD]) begin
            n_q = (QD + 1)'(div_s[QD]);
        end else if (div_sneg[QD] != div_vneg[QD]) begin
            n_q = -q_pos;
        end else begin
            n_q = q_pos;
        end

        w_sum = WW'(r_q) + $signed(ADDC);
        w_sh  = w_sum >>> SH;
        if ((w_sh[WW-1:31] == '0) || (w_sh[WW-1:31] == '1)) begin
            n_res.value = w_sh[31:0];
            n_res.clip  = 1'b0;
        end else begin
            n_res.value = w_sh[WW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            n_res.clip  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q   <= n_q;
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ===== hw/rtl/pixel_sinc_wave_top.sv =====
// Top level of the pixel sinc wave block: configuration registers, four channel lanes
// and the flow control. Depends on psw_pkg and psw_channel.
//
// A pixel of four signed channels arrives on the s_axis channel, one channel per
// 32-bit slice of tdata. The result pixel leaves on m_axis with the four sinc values in
// tdata and the saturation flag in tuser. Each lane is a row of cells that hands its
// data on every cycle the pipeline is not frozen, so one pixel is accepted per cycle.
// The delay from an accepted input transaction to the matching output is set by the
// reduction, sine series and quotient cells. The whole pipeline advances together; when
// the receiver holds m_axis_tready low with a result waiting, the pipeline freezes and
// s_axis_tready falls in the same cycle. Reset empties the pipeline and clears the
// configuration (normal mode, zero phases). Configuration is written through i_cfg_we,
// i_cfg_addr and i_cfg_data; the user must do so only while the block holds no pixel,
// which the block does not enforce. Writes to unknown indices are ignored.
`timescale 1ns / 1ps
`default_nettype none

module pixel_sinc_wave_top #(
    parameter int FRAC_BITS  = 16,
    parameter int SINE_STEPS = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // in_x, in_y, in_z, in_w from bit 0 up.
    input  logic [127:0]                s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_x, out_y, out_z, out_w from bit 0 up.
    output logic [127:0]                m_axis_tdata,
    // clipped.
    output logic [0:0]                  m_axis_tuser,
    input  logic                        i_cfg_we,
    input  logic [psw_pkg::CFG_W-1:0]   i_cfg_addr,
    input  logic [31:0]                 i_cfg_data
);

    localparam int LAT = psw_pkg::latency(SINE_STEPS);

    logic               r_equal_mode;
    logic signed [31:0] r_phase_x, r_phase_y, r_phase_z, r_phase_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_equal_mode <= 1'b0;
            r_phase_x    <= '0;
            r_phase_y    <= '0;
            r_phase_z    <= '0;
            r_phase_w    <= '0;
        end else if (i_cfg_we) begin
            unique case (psw_pkg::t_cfg_idx'(i_cfg_addr))
                psw_pkg::CFG_EQUAL_MODE: r_equal_mode <= i_cfg_data[0];
                psw_pkg::CFG_PHASE_X:    r_phase_x    <= i_cfg_data;
                psw_pkg::CFG_PHASE_Y:    r_phase_y    <= i_cfg_data;
                psw_pkg::CFG_PHASE_Z:    r_phase_z    <= i_cfg_data;
                psw_pkg::CFG_PHASE_W:    r_phase_w    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    logic               en;
    logic [LAT-1:0]     r_vld;
    logic [LAT-1:0]     r_eq;
    logic signed [31:0] ch_v [4];
    logic signed [31:0] ch_t [4];
    psw_pkg::t_chan_res ch_res [4];

    assign en            = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_eq <= {r_eq[LAT-2:0], r_equal_mode};
        end
    end

    always_comb begin
        ch_v[0] = s_axis_tdata[31:0];
        ch_v[1] = s_axis_tdata[63:32];
        ch_v[2] = s_axis_tdata[95:64];
        ch_v[3] = s_axis_tdata[127:96];
        ch_t[0] = r_phase_x;
        ch_t[1] = r_phase_y;
        ch_t[2] = r_phase_z;
        ch_t[3] = r_equal_mode ? r_phase_y : r_phase_w;
    end

    for (genvar c = 0; c < 4; c++) begin : g_ch
        psw_channel #(
            .FRAC_BITS (FRAC_BITS),
            .SINE_STEPS(SINE_STEPS)
        ) u_channel (
            .i_clk(i_clk),
            .i_en (en),
            .i_v  (ch_v[c]),
            .i_t  (ch_t[c]),
            .o_res(ch_res[c])
        );
    end

    always_comb begin
        if (r_eq[LAT-1]) begin
            m_axis_tdata    = {4{ch_res[3].value}};
            m_axis_tuser[0] = ch_res[3].clip;
        end else begin
            m_axis_tdata    = {ch_res[3].value, ch_res[2].value,
                               ch_res[1].value, ch_res[0].value};
            m_axis_tuser[0] = ch_res[0].clip | ch_res[1].clip
                            | ch_res[2].clip | ch_res[3].clip;
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_pixel_sinc_wave_top.sv =====
// Testbench for pixel_sinc_wave_top: drives pixels and configuration writes, predicts each
// result pixel in fixed point and compares it field by field. Depends on psw_pkg and the RTL.
`timescale 1ns / 1ps

module tb_pixel_sinc_wave_top;

    localparam int FRAC      = 16;
    localparam int STEPS     = 20;
    localparam int LAT       = 3 * STEPS + 67;
    localparam int WDOG_MAX  = 20000;
    localparam logic [63:0] PI62 = 64'hC90FDAA22168C235;

    typedef struct packed {
        logic [31:0] w;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } t_pix;

    typedef struct {
        t_pix pix;
        logic clip;
    } t_sinc_res;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         i_cfg_we;
    logic [psw_pkg::CFG_W-1:0] i_cfg_addr;
    logic [31:0]  i_cfg_data;

    pixel_sinc_wave_top #(.FRAC_BITS(FRAC), .SINE_STEPS(STEPS)) dut (.*);

    logic        eq_mode;
    logic [31:0] ph_x, ph_y, ph_z, ph_w;
    t_sinc_res   sinc_fifo[$];
    int          n_errors;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint sine_q30(longint s);
        longint tp, pi30, hp30, r, sum;
        longint unsigned mag, r2, term;
        bit neg;
        tp   = longint'(((PI62 >> (32 - FRAC)) + 64'd1) >> 1);
        pi30 = longint'(((PI62 >> 31) + 64'd1) >> 1);
        hp30 = longint'(((PI62 >> 32) + 64'd1) >> 1);
        r = (s * (longint'(1) << 28)) % tp;
        neg = 1'b0;
        if (r < 0) r += tp;
        r = r >>> (FRAC - 2);
        if (r >= pi30) begin
            neg = 1'b1;
            r -= pi30;
        end
        if (r > hp30) begin
            r = pi30 - r;
            if (r < 0) r = 0;
        end
        mag  = longint'(r);
        r2   = (mag * mag) >> 30;
        term = mag;
        sum  = longint'(mag);
        for (int k = 1; k < STEPS; k++) begin
            term = ((term * r2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k & 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        return neg ? -sum : sum;
    endfunction

    function automatic logic [31:0] sinc_channel(logic [31:0] vin, logic [31:0] tin,
                                                 inout logic clip);
        longint v, s, q, w, qm;
        longint unsigned sm, vm;
        int sh;
        v  = longint'(signed'(vin));
        s  = sine_q30(v + longint'(signed'(tin)));
        sh = 31 - FRAC;
        if (v != 0) begin
            sm = (s < 0) ? -s : s;
            vm = (v < 0) ? -v : v;
            qm = longint'((sm << FRAC) / vm);
            q  = ((s < 0) != (v < 0)) ? -qm : qm;
        end else begin
            q = s;
        end
        w = q + (longint'(1) << 30) + (longint'(1) << (30 - FRAC));
        w = w >>> sh;
        if (w > 64'sh7FFFFFFF) begin
            w = 64'sh7FFFFFFF;
            clip = 1'b1;
        end else if (w < -64'sh80000000) begin
            w = -64'sh80000000;
            clip = 1'b1;
        end
        return w[31:0];
    endfunction

    function automatic t_sinc_res predict_sinc(t_pix p);
        t_sinc_res r;
        logic [31:0] v;
        r.clip = 1'b0;
        if (eq_mode) begin
            v = sinc_channel(p.w, ph_y, r.clip);
            r.pix = {v, v, v, v};
        end else begin
            r.pix.x = sinc_channel(p.x, ph_x, r.clip);
            r.pix.y = sinc_channel(p.y, ph_y, r.clip);
            r.pix.z = sinc_channel(p.z, ph_z, r.clip);
            r.pix.w = sinc_channel(p.w, ph_w, r.clip);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        n_errors++;
    endtask

    task automatic send_pixel(t_pix p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sinc_fifo.push_back(predict_sinc(p));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sinc_fifo.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(psw_pkg::t_cfg_idx idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            psw_pkg::CFG_EQUAL_MODE: eq_mode = val[0];
            psw_pkg::CFG_PHASE_X:    ph_x = val;
            psw_pkg::CFG_PHASE_Y:    ph_y = val;
            psw_pkg::CFG_PHASE_Z:    ph_z = val;
            psw_pkg::CFG_PHASE_W:    ph_w = val;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_chan();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            2: return $urandom_range(1) ? $urandom_range(64) : -$urandom_range(64);
            3: return $urandom_range(1) ? $urandom_range(32'h40000) : -$urandom_range(32'h40000);
            default: return $urandom;
        endcase
    endfunction

    task automatic set_phases(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [31:0] pw);
        write_reg(psw_pkg::CFG_PHASE_X, px);
        write_reg(psw_pkg::CFG_PHASE_Y, py);
        write_reg(psw_pkg::CFG_PHASE_Z, pz);
        write_reg(psw_pkg::CFG_PHASE_W, pw);
    endtask

    task automatic test_directed_edges();
        logic [31:0] vals[8] = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'hFFFFFFFF,
                                 32'h00010000, 32'hFFFF0000, 32'h0001921F};
        for (int i = 0; i < 8; i++)
            send_pixel('{w: vals[i], z: vals[(i + 3) % 8], y: vals[(i + 5) % 8],
                         x: vals[(i + 1) % 8]});
        send_pixel('{w: 32'h1, z: 32'h1, y: 32'hFFFFFFFF, x: 32'h2});
        wait_drained();
        set_phases(32'h7FFFFFFF, 32'h80000000, 32'h00019220, 32'hFFFE6DE0);
        for (int i = 0; i < 6; i++)
            send_pixel('{w: vals[i], z: vals[i + 1], y: vals[i + 2], x: vals[i]});
        wait_drained();
        write_reg(psw_pkg::CFG_EQUAL_MODE, 32'hFFFFFFFF);
        for (int i = 0; i < 6; i++)
            send_pixel('{w: vals[i], z: $urandom, y: $urandom, x: $urandom});
    endtask

    task automatic test_random_phase(int n_pix);
        wait_drained();
        write_reg(psw_pkg::CFG_EQUAL_MODE, $urandom_range(3) == 0);
        set_phases(rand_chan(), rand_chan(), rand_chan(), rand_chan());
        for (int i = 0; i < n_pix; i++)
            send_pixel('{w: rand_chan(), z: rand_chan(), y: rand_chan(), x: rand_chan()});
    endtask

    task automatic test_pause_until_drained();
        for (int i = 0; i < 5; i++)
            send_pixel('{w: rand_chan(), z: rand_chan(), y: rand_chan(), x: rand_chan()});
        s_axis_tvalid <= 1'b0;
        while (sinc_fifo.size() != 0) @(posedge i_clk);
        for (int i = 0; i < 5; i++)
            send_pixel('{w: rand_chan(), z: rand_chan(), y: rand_chan(), x: rand_chan()});
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_sinc_res want;
        t_pix got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (sinc_fifo.size() == 0) begin
                $display("unexpected result pixel %h", m_axis_tdata);
                n_errors++;
            end else begin
                want = sinc_fifo.pop_front();
                if (got.x !== want.pix.x) report_mismatch("out_x", got.x, want.pix.x);
                if (got.y !== want.pix.y) report_mismatch("out_y", got.y, want.pix.y);
                if (got.z !== want.pix.z) report_mismatch("out_z", got.z, want.pix.z);
                if (got.w !== want.pix.w) report_mismatch("out_w", got.w, want.pix.w);
                if (m_axis_tuser[0] !== want.clip)
                    report_mismatch("clipped", 32'(m_axis_tuser), 32'(want.clip));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        eq_mode = 1'b0;
        {ph_x, ph_y, ph_z, ph_w} = '0;
        n_errors = 0;
        idle_cycles = 0;
        send_idle_pct = 33;
        recv_idle_pct = 59;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_pause_until_drained();
        for (int i = 0; i < 8; i++) test_random_phase(25);
        send_idle_pct = 59;
        recv_idle_pct = 33;
        for (int i = 0; i < 8; i++) test_random_phase(25);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 8; i++) test_random_phase(25);
        wait_drained();
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
